/* rtl/ordered_key_set_range_sum_core_macros.svh */
// assertion macros shared by the checker files
`ifndef ORDERED_KEY_SET_RANGE_SUM_CORE_MACROS_SVH
`define ORDERED_KEY_SET_RANGE_SUM_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OKSRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oksrs check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define OKSRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oksrs check failed");

`endif

/* rtl/oksrs_pkg.sv */
// types, codes and sizing shared by the key set range sum block
`default_nettype none

package oksrs_pkg;

    // number of key cells in the chain
    localparam int CAPACITY = 1024;

    localparam int KEY_W = 30;
    localparam int BOUND_W = 32;
    localparam int SUM_W = 40;
    localparam int STATUS_W = 2;

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // result codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_QUERY = 2'd3;

    typedef struct packed {
        logic                      req_type;
        logic [KEY_W-1:0]          key;
        logic signed [BOUND_W-1:0] range_low;
        logic signed [BOUND_W-1:0] range_high;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SUM_W-1:0]    range_sum;
    } rsp_t;

    // what travels from one cell to the next along with a request
    typedef struct packed {
        logic                      req_type;
        logic [KEY_W-1:0]          key;
        logic signed [BOUND_W-1:0] range_low;
        logic signed [BOUND_W-1:0] range_high;
        logic [SUM_W-1:0]          sum;
        logic                      found;
        logic                      placed;
    } pay_t;

    typedef struct packed {
        logic valid;
        pay_t pay;
    } beat_t;

endpackage

`default_nettype wire

/* rtl/oksrs_cell.sv */
// one key cell: holds a key, checks and updates the passing request
`default_nettype none

module oksrs_cell
    import oksrs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire beat_t beat_in,
    output beat_t      beat_out
);

    logic [KEY_W-1:0]          key_reg;
    logic                      used_reg;
    logic                      used_next;
    logic                      valid_reg;
    pay_t                      pay_reg;
    pay_t                      pay_next;
    logic                      store_en;
    logic                      in_range;
    logic signed [BOUND_W-1:0] key_ext;

    assign key_ext = signed'({{(BOUND_W-KEY_W){1'b0}}, key_reg});
    assign in_range = (key_ext >= beat_in.pay.range_low)
                   && (key_ext <= beat_in.pay.range_high);

    // first empty cell takes the key when no earlier cell held it
    assign store_en = beat_in.valid && (beat_in.pay.req_type == REQ_INSERT)
                   && !used_reg && !beat_in.pay.found && !beat_in.pay.placed;
    assign used_next = used_reg | store_en;

    always_comb
    begin
        pay_next = beat_in.pay;
        if (beat_in.pay.req_type == REQ_INSERT)
        begin
            pay_next.found = beat_in.pay.found
                          | (used_reg && (key_reg == beat_in.pay.key));
            pay_next.placed = beat_in.pay.placed | store_en;
        end
        else if (used_reg && in_range)
        begin
            pay_next.sum = beat_in.pay.sum + {{(SUM_W-KEY_W){1'b0}}, key_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            used_reg  <= used_next;
            valid_reg <= beat_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pay_reg <= pay_next;
        end
        if (advance && store_en)
        begin
            key_reg <= beat_in.pay.key;
        end
    end

    assign beat_out = '{valid: valid_reg, pay: pay_reg};

endmodule

`default_nettype wire

/* rtl/ordered_key_set_range_sum_core.sv */
// top level: a chain of key cells holding a set of distinct keys
//
// usage
//   req channel (req_valid/req_ready/req) carries one beat per request:
//   req_type 0 inserts req.key, req_type 1 asks for the sum of stored keys
//   between range_low and range_high, both signed and inclusive
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one beat per request in
//   request order: status inserted, duplicate, full or query answered,
//   and the range sum (zero for inserts, wraps at 40 bits)
// timing
//   each request walks the chain one cell per cycle while the chain moves,
//   and rsp_valid rises from the response register behind the last cell
//   one request per cycle is taken while nothing stalls; the rate is set by
//   the chain advancing one cell each cycle, the latency by the chain length
// stalls
//   the whole chain and the response register move together; while a
//   response waits with rsp_ready low, req_ready is low and nothing moves
// reset
//   rst_n clears every cell's used flag and all beat valid bits, so the
//   set starts empty; ready is high on the first cycle after reset
`default_nettype none

module ordered_key_set_range_sum_core
    import oksrs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    // chain[i] feeds cell i; chain[CAPACITY] leaves the last cell
    beat_t chain [CAPACITY+1];

    logic  advance;
    logic  rsp_valid_reg;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;

    // chain moves when the response register is empty or being emptied
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = advance;

    // head of the chain: fresh request with clean flags and zero sum
    assign chain[0] = '{
        valid: req_valid,
        pay: '{
            req_type:   req.req_type,
            key:        req.key,
            range_low:  req.range_low,
            range_high: req.range_high,
            sum:        '0,
            found:      1'b0,
            placed:     1'b0
        }
    };

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        oksrs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .beat_in  (chain[i]),
            .beat_out (chain[i+1])
        );
    end

    // result code from the flags gathered along the chain
    always_comb
    begin
        rsp_next.range_sum = chain[CAPACITY].pay.sum;
        priority if (chain[CAPACITY].pay.req_type == REQ_QUERY)
        begin
            rsp_next.status = ST_QUERY;
        end
        else if (chain[CAPACITY].pay.found)
        begin
            // a stored key wins over a full store
            rsp_next.status = ST_DUPLICATE;
        end
        else if (chain[CAPACITY].pay.placed)
        begin
            rsp_next.status = ST_INSERTED;
        end
        else
        begin
            // reached the end with every cell taken
            rsp_next.status = ST_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= chain[CAPACITY].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* rtl/oksrs_checker.sv */
// port-level checks for the key set range sum block, bound to the top level
`default_nettype none
`include "ordered_key_set_range_sum_core_macros.svh"

module oksrs_checker
    import oksrs_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    // a waiting response holds steady
    `OKSRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // inserts never carry a sum
    `OKSRS_ASSERT_NOW(a_insert_zero_sum, rsp_valid && (rsp.status != ST_QUERY), rsp.range_sum == '0)

    // a stalled response blocks new requests
    `OKSRS_ASSERT_NOW(a_stall_blocks, rsp_valid && !rsp_ready, !req_ready)

    // an empty response slot always lets requests in
    `OKSRS_ASSERT_NOW(a_free_ready, !rsp_valid, req_ready)

    // a waiting request beat holds steady
    `OKSRS_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req))

endmodule

bind ordered_key_set_range_sum_core oksrs_checker u_oksrs_checker (.*);

`default_nettype wire
